// ===== hw/rtl/chnd_pkg.sv =====
// chnd_pkg: shared constants, codes and types of the context huffman nibble decoder
// no dependencies; imported by every module of the block
`default_nettype none

package chnd_pkg;

   localparam int MAX_CODE_BITS = 8;
   localparam int NUM_CONTEXTS  = 3;
   localparam int FRAME_BYTES   = 9;

   localparam int SYMS        = 16;
   localparam int SYM_W       = 4;
   localparam int LEN_W       = 4;
   localparam int CODE_W      = 8;
   localparam int BYTE_W      = 8;
   localparam int SKIP_W      = 3;
   localparam int CTX_W       = 2;
   localparam int ENTRY_W     = LEN_W + CODE_W;
   localparam int ROW_W       = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam int BUF_W       = 15;
   localparam int CNT_W       = 4;
   localparam int POS_W       = $clog2(2 * FRAME_BYTES);
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * FRAME_BYTES - 1);

   typedef enum logic [1:0] {
      OP_DEFINE = 2'd0,
      OP_START  = 2'd1,
      OP_DATA   = 2'd2
   } op_type;

   typedef struct packed {
      logic define;
      logic start;
      logic append;
      logic step;
      logic handoff;
   } ctrl_cmd_type;

   typedef struct packed {
      logic enough;
      logic batch_empty;
   } dp_status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_end;
      logic              code_error;
   } rslt_type;

endpackage

`default_nettype wire

// ===== hw/rtl/chnd_ctrl.sv =====
// chnd_ctrl: controller state machine, sequences accept, decode steps and handoff
// depends on chnd_pkg
`default_nettype none

module chnd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_operation,
   output logic                    req_ready,
   input  chnd_pkg::dp_status_type status,
   input  logic                    out_free,
   output chnd_pkg::ctrl_cmd_type  cmd
);
   import chnd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DECODE
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.define = accept && (req_operation == OP_DEFINE);
            cmd.start  = accept && (req_operation == OP_START);
            cmd.append = accept && (req_operation == OP_DATA);
            if (cmd.append) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.enough) begin
               cmd.step = 1'b1;
            end else if (status.batch_empty) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.handoff = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/chnd_datapath.sv =====
// chnd_datapath: code table memory, bit buffer, symbol matcher and result batch
// depends on chnd_pkg; driven by chnd_ctrl commands
`default_nettype none

module chnd_datapath (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  chnd_pkg::ctrl_cmd_type                                  cmd,
   input  logic [chnd_pkg::CTX_W-1:0]                              req_context_req,
   input  logic [chnd_pkg::SYM_W-1:0]                              req_symbol,
   input  logic [chnd_pkg::LEN_W-1:0]                              req_code_length,
   input  logic [chnd_pkg::CODE_W-1:0]                             req_code_bits,
   input  logic [chnd_pkg::SKIP_W-1:0]                             req_skip_bits,
   input  logic [chnd_pkg::BYTE_W-1:0]                             req_data_byte,
   output chnd_pkg::dp_status_type                                 status,
   output chnd_pkg::rslt_type [chnd_pkg::MAX_RESULTS-1:0]          batch,
   output logic [chnd_pkg::NUM_W-1:0]                              batch_num
);
   import chnd_pkg::*;

   function automatic logic [ROW_W-1:0] ctx_of(input logic [POS_W-1:0] pos);
      logic [ROW_W-1:0] ctx;
      if (pos == '0) begin
         ctx = ROW_W'(0);
      end else if (pos == POS_W'(1)) begin
         ctx = ROW_W'(1);
      end else begin
         ctx = ROW_W'(2);
      end
      return ctx;
   endfunction

   logic [SYMS-1:0][ENTRY_W-1:0]      tbl_mem [NUM_CONTEXTS];
   logic [SYMS-1:0][ENTRY_W-1:0]      row_ff;
   logic [NUM_CONTEXTS-1:0][SYMS-1:0] valid_ff, valid_in;
   logic [BUF_W-1:0]                  buf_ff, buf_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic [SYM_W-1:0]                  held_ff, held_in;
   logic [SKIP_W-1:0]                 skip_ff, skip_in;
   rslt_type [MAX_RESULTS-1:0]        slot_ff, slot_in;
   logic [NUM_W-1:0]                  num_ff, num_in;

   logic                       def_ok;
   logic [ROW_W-1:0]           ctx_cur;
   logic [ROW_W-1:0]           rd_row;
   logic [CNT_W-1:0]           keep;
   logic [BYTE_W-1:0]          kept;
   logic [BUF_W+BYTE_W-1:0]    joined;
   logic [MAX_CODE_BITS-1:0]   window;
   logic [CODE_W-1:0]          win_ext;
   logic [SYMS-1:0]            hit;
   logic                       found;
   logic [SYM_W-1:0]           sym;
   logic [LEN_W-1:0]           len;
   logic [CNT_W-1:0]           cnt_left;
   logic                       fend;
   logic                       has_room;

   assign def_ok  = {1'b0, req_context_req} < (CTX_W + 1)'(NUM_CONTEXTS);
   assign ctx_cur = ctx_of(pos_ff);
   assign rd_row  = ctx_of(pos_in);

   assign status.enough      = (cnt_ff >= CNT_W'(MAX_CODE_BITS));
   assign status.batch_empty = (num_ff == '0);
   assign batch              = slot_ff;
   assign batch_num          = num_ff;

   // match the top code window against the current context
   always_comb begin
      logic [LEN_W-1:0]  e_len;
      logic [CODE_W-1:0] e_code;
      window  = MAX_CODE_BITS'(buf_ff >> (cnt_ff - CNT_W'(MAX_CODE_BITS)));
      win_ext = CODE_W'(window);
      for (int s = 0; s < SYMS; s++) begin
         e_len  = row_ff[s][ENTRY_W-1:CODE_W];
         e_code = row_ff[s][CODE_W-1:0];
         hit[s] = valid_ff[ctx_cur][s] && (e_len != '0)
                  && (e_len <= LEN_W'(MAX_CODE_BITS))
                  && ((win_ext >> (LEN_W'(MAX_CODE_BITS) - e_len))
                      == (e_code & ~({CODE_W{1'b1}} << e_len)));
      end
      found = 1'b0;
      sym   = '0;
      for (int s = 0; s < SYMS; s++) begin
         if (hit[s]) begin
            found = 1'b1;
            sym   = SYM_W'(s);
         end
      end
      len      = row_ff[sym][ENTRY_W-1:CODE_W];
      cnt_left = cnt_ff - CNT_W'(len);
   end

   always_comb begin
      valid_in = valid_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      held_in  = held_ff;
      skip_in  = skip_ff;
      slot_in  = slot_ff;
      num_in   = num_ff;
      keep     = CNT_W'(BYTE_W) - CNT_W'(skip_ff);
      kept     = req_data_byte & ({BYTE_W{1'b1}} >> skip_ff);
      joined   = ({{BYTE_W{1'b0}}, buf_ff} << keep) | (BUF_W + BYTE_W)'(kept);
      fend     = (pos_ff >= LAST_POS);
      has_room = (num_ff < NUM_W'(MAX_RESULTS));

      if (cmd.define && def_ok) begin
         valid_in[req_context_req[ROW_W-1:0]][req_symbol] = 1'b1;
      end
      if (cmd.start) begin
         buf_in  = '0;
         cnt_in  = '0;
         pos_in  = '0;
         held_in = '0;
         skip_in = req_skip_bits;
      end
      if (cmd.append) begin
         buf_in  = joined[BUF_W-1:0];
         cnt_in  = cnt_ff + keep;
         skip_in = '0;
      end
      if (cmd.step) begin
         if (!found) begin
            buf_in = '0;
            cnt_in = '0;
            if (has_room) begin
               slot_in[num_ff[SLOT_W-1:0]].out_byte   = '0;
               slot_in[num_ff[SLOT_W-1:0]].frame_end  = 1'b0;
               slot_in[num_ff[SLOT_W-1:0]].code_error = 1'b1;
               num_in = num_ff + NUM_W'(1);
            end else begin
               slot_in[MAX_RESULTS-1].code_error = 1'b1;
            end
         end else begin
            cnt_in = cnt_left;
            buf_in = buf_ff & ~({BUF_W{1'b1}} << cnt_left);
            if (!pos_ff[0]) begin
               held_in = sym;
               pos_in  = pos_ff + POS_W'(1);
            end else begin
               if (has_room) begin
                  slot_in[num_ff[SLOT_W-1:0]].out_byte   = {held_ff, sym};
                  slot_in[num_ff[SLOT_W-1:0]].frame_end  = fend;
                  slot_in[num_ff[SLOT_W-1:0]].code_error = 1'b0;
                  num_in = num_ff + NUM_W'(1);
               end
               held_in = '0;
               pos_in  = fend ? '0 : pos_ff + POS_W'(1);
            end
         end
      end
      if (cmd.handoff) begin
         num_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         buf_ff   <= '0;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         held_ff  <= '0;
         skip_ff  <= '0;
         num_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         skip_ff  <= skip_in;
         num_ff   <= num_in;
      end
   end

   // code table: one row per context, read a whole row each cycle
   always_ff @(posedge clock) begin
      if (cmd.define && def_ok) begin
         tbl_mem[req_context_req[ROW_W-1:0]][req_symbol] <= {req_code_length, req_code_bits};
      end
      row_ff  <= tbl_mem[rd_row];
      slot_ff <= slot_in;
   end

   a_num_bound: assert property (@(posedge clock) disable iff (reset)
      num_ff <= NUM_W'(MAX_RESULTS))
      else $error("result batch count exceeds slot count");

   a_step_consumes: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (cnt_ff < $past(cnt_ff)))
      else $error("decode step did not consume buffered bits");

   a_handoff_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.handoff |-> (num_ff != '0))
      else $error("handoff of an empty batch");

endmodule

`default_nettype wire

// ===== hw/rtl/chnd_rsp_buf.sv =====
// chnd_rsp_buf: output buffer holding one batch of result words for the rsp channel
// depends on chnd_pkg; loaded with the chnd_datapath batch on the chnd_ctrl handoff command
`default_nettype none

module chnd_rsp_buf (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            load,
   input  chnd_pkg::rslt_type [chnd_pkg::MAX_RESULTS-1:0]  batch,
   input  logic [chnd_pkg::NUM_W-1:0]                      batch_num,
   output logic                                            free,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic [chnd_pkg::BYTE_W-1:0]                     rsp_out_byte,
   output logic                                            rsp_frame_end,
   output logic                                            rsp_code_error,
   output logic                                            rsp_last
);
   import chnd_pkg::*;

   rslt_type [MAX_RESULTS-1:0] slot_ff;
   logic [NUM_W-1:0]           cnt_ff, cnt_in;
   logic [SLOT_W-1:0]          idx_ff, idx_in;
   logic                       final_word;

   assign final_word     = ((NUM_W'(idx_ff) + NUM_W'(1)) == cnt_ff);
   assign rsp_valid      = (cnt_ff != '0);
   assign free           = (cnt_ff == '0);
   assign rsp_out_byte   = slot_ff[idx_ff].out_byte;
   assign rsp_frame_end  = slot_ff[idx_ff].frame_end;
   assign rsp_code_error = slot_ff[idx_ff].code_error;
   assign rsp_last       = final_word;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = batch_num;
         idx_in = '0;
      end else if (rsp_valid && rsp_ready) begin
         if (final_word) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= batch;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == '0))
      else $error("batch loaded over undelivered words");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (NUM_W'(idx_ff) < cnt_ff))
      else $error("read index past batch end");

endmodule

`default_nettype wire

// ===== hw/rtl/context_huffman_nibble_decoder.sv =====
// context_huffman_nibble_decoder: top level, joins chnd_ctrl, chnd_datapath, chnd_rsp_buf
// depends on chnd_pkg and the three modules above
// req channel: define symbol code, start stream, or one compressed data byte per word
// rsp channel: decoded bytes (two nibbles) or error words, rsp_last on the final word of a req
// define and start words produce no rsp word
// a data word appends its byte, then makes k decode steps through the context row matcher,
// one per symbol or error (0 to 8), then finishes: it hands its batch to the output buffer,
// or goes back to idle if the batch is empty
// the code table is read one context row per cycle, which sets the one-symbol-per-cycle pace
// up to four rsp words per data word go to an output buffer, presented one per cycle
// while rsp_ready is high; the next req word is taken while the buffer still drains
// if the receiver stalls and the buffer still holds words when the next batch is ready,
// req_ready stays low until the buffer empties
// reset: all symbols undefined, bit buffer and frame position cleared, no clearing pass
`default_nettype none

module context_huffman_nibble_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_operation,
   input  logic [chnd_pkg::CTX_W-1:0]       req_context_req,
   input  logic [chnd_pkg::SYM_W-1:0]       req_symbol,
   input  logic [chnd_pkg::LEN_W-1:0]       req_code_length,
   input  logic [chnd_pkg::CODE_W-1:0]      req_code_bits,
   input  logic [chnd_pkg::SKIP_W-1:0]      req_skip_bits,
   input  logic [chnd_pkg::BYTE_W-1:0]      req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [chnd_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_frame_end,
   output logic                             rsp_code_error,
   output logic                             rsp_last
);
   import chnd_pkg::*;

   ctrl_cmd_type               cmd;
   dp_status_type              status;
   logic                       out_free;
   rslt_type [MAX_RESULTS-1:0] batch;
   logic [NUM_W-1:0]           batch_num;

   chnd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .out_free      (out_free),
      .cmd           (cmd)
   );

   chnd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_context_req (req_context_req),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .req_code_bits   (req_code_bits),
      .req_skip_bits   (req_skip_bits),
      .req_data_byte   (req_data_byte),
      .status          (status),
      .batch           (batch),
      .batch_num       (batch_num)
   );

   chnd_rsp_buf u_rsp_buf (
      .clock          (clock),
      .reset          (reset),
      .load           (cmd.handoff),
      .batch          (batch),
      .batch_num      (batch_num),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_code_error (rsp_code_error),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== test/chnd_checker.sv =====
`timescale 1ns / 100ps
// chnd_checker: watches the req and rsp channels of context_huffman_nibble_decoder, keeps its
// own copy of the code tables and bit stream, and compares each rsp word field by field
// depends on chnd_pkg; instantiated beside the decoder by tb_top
module chnd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [chnd_pkg::CTX_W-1:0]      req_context_req,
   input  logic [chnd_pkg::SYM_W-1:0]      req_symbol,
   input  logic [chnd_pkg::LEN_W-1:0]      req_code_length,
   input  logic [chnd_pkg::CODE_W-1:0]     req_code_bits,
   input  logic [chnd_pkg::SKIP_W-1:0]     req_skip_bits,
   input  logic [chnd_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [chnd_pkg::BYTE_W-1:0]     rsp_out_byte,
   input  logic                            rsp_frame_end,
   input  logic                            rsp_code_error,
   input  logic                            rsp_last,
   output int                              fail_count,
   output int                              words_waiting,
   output int                              words_checked,
   output int                              errors_seen
);
   import chnd_pkg::*;

   localparam int TABLE_DEPTH = NUM_CONTEXTS * SYMS;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_end;
      logic              code_error;
      logic              last;
   } dec_word_type;

   logic [LEN_W-1:0]  sym_len  [TABLE_DEPTH];
   logic [CODE_W-1:0] sym_code [TABLE_DEPTH];
   logic [BUF_W-1:0]  bits_held;
   int                bits_avail;
   logic [POS_W-1:0]  nib_pos;
   logic [SYM_W-1:0]  hi_nibble;
   logic [SKIP_W-1:0] drop_bits;
   dec_word_type      expected_words [$];

   function automatic int lookup_symbol(input int ctx, input logic [CODE_W-1:0] window);
      int hit;
      int len;
      logic [CODE_W-1:0] mask;
      hit = -1;
      for (int s = 0; s < SYMS; s++) begin
         len = sym_len[ctx * SYMS + s];
         if (len >= 1 && len <= MAX_CODE_BITS) begin
            mask = CODE_W'((1 << len) - 1);
            if ((window >> (MAX_CODE_BITS - len)) == (sym_code[ctx * SYMS + s] & mask)) begin
               hit = s;
            end
         end
      end
      return hit;
   endfunction

   task automatic predict_decode(input logic [1:0] op, input logic [CTX_W-1:0] ctx_f,
                                 input logic [SYM_W-1:0] sym_f, input logic [LEN_W-1:0] len_f,
                                 input logic [CODE_W-1:0] code_f,
                                 input logic [SKIP_W-1:0] skip_f,
                                 input logic [BYTE_W-1:0] byte_f);
      dec_word_type      batch [$];
      dec_word_type      w;
      logic [BYTE_W-1:0] fresh;
      logic [CODE_W-1:0] window;
      logic              fend;
      int                keep;
      int                ctx;
      int                hit;
      case (op)
         OP_DEFINE: begin
            if (int'(ctx_f) < NUM_CONTEXTS) begin
               sym_len[int'(ctx_f) * SYMS + int'(sym_f)] = len_f;
               sym_code[int'(ctx_f) * SYMS + int'(sym_f)] = code_f;
            end
         end
         OP_START: begin
            bits_held = '0;
            bits_avail = 0;
            nib_pos = '0;
            hi_nibble = '0;
            drop_bits = skip_f;
         end
         OP_DATA: begin
            keep = 8 - int'(drop_bits);
            fresh = BYTE_W'(int'(byte_f) & ((1 << keep) - 1));
            drop_bits = '0;
            bits_held = BUF_W'((int'(bits_held) << keep) | int'(fresh));
            bits_avail += keep;
            while (bits_avail >= MAX_CODE_BITS) begin
               ctx = (nib_pos == 0) ? 0 : (nib_pos == 1) ? 1 : 2;
               window = CODE_W'(int'(bits_held) >> (bits_avail - MAX_CODE_BITS));
               hit = lookup_symbol(ctx, window);
               if (hit < 0) begin
                  bits_held = '0;
                  bits_avail = 0;
                  if (batch.size() < MAX_RESULTS) begin
                     w = '{BYTE_W'(0), 1'b0, 1'b1, 1'b0};
                     batch.push_back(w);
                  end else begin
                     w = batch.pop_back();
                     w.code_error = 1'b1;
                     batch.push_back(w);
                  end
               end else begin
                  bits_avail -= int'(sym_len[ctx * SYMS + hit]);
                  bits_held = BUF_W'(int'(bits_held) & ((1 << bits_avail) - 1));
                  if (!nib_pos[0]) begin
                     hi_nibble = SYM_W'(hit);
                     nib_pos = nib_pos + 1'b1;
                  end else begin
                     fend = (nib_pos >= LAST_POS);
                     if (batch.size() < MAX_RESULTS) begin
                        w = '{{hi_nibble, SYM_W'(hit)}, fend, 1'b0, 1'b0};
                        batch.push_back(w);
                     end
                     hi_nibble = '0;
                     nib_pos = fend ? '0 : nib_pos + 1'b1;
                  end
               end
            end
            if (batch.size() > 0) begin
               w = batch.pop_back();
               w.last = 1'b1;
               batch.push_back(w);
            end
            foreach (batch[i]) expected_words.push_back(batch[i]);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] rsp %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_word();
      dec_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("word with nothing expected, out_byte", int'(rsp_out_byte), 0);
      end else begin
         want = expected_words.pop_front();
         if (rsp_out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(rsp_out_byte), int'(want.out_byte));
         if (rsp_frame_end !== want.frame_end)
            report_mismatch("frame_end", int'(rsp_frame_end), int'(want.frame_end));
         if (rsp_code_error !== want.code_error)
            report_mismatch("code_error", int'(rsp_code_error), int'(want.code_error));
         if (rsp_last !== want.last)
            report_mismatch("last", int'(rsp_last), int'(want.last));
      end
      words_checked++;
      if (rsp_code_error === 1'b1) errors_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            sym_len[i] = 4'hF;
            sym_code[i] = '0;
         end
         bits_held = '0;
         bits_avail = 0;
         nib_pos = '0;
         hi_nibble = '0;
         drop_bits = '0;
         expected_words.delete();
         fail_count = 0;
         words_checked = 0;
         errors_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         if (req_valid && req_ready) begin
            predict_decode(req_operation, req_context_req, req_symbol, req_code_length,
                           req_code_bits, req_skip_bits, req_data_byte);
         end
      end
      words_waiting = expected_words.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: clock, reset, req stimulus and rsp back-pressure for context_huffman_nibble_decoder
// depends on chnd_pkg, the decoder rtl and chnd_checker, which does all the predicting
module tb_top;
   import chnd_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int PERIOD      = 12;
   localparam int TOTAL_WORDS = 450;
   localparam int CALM_WORDS  = 60;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_operation = '0;
   logic [CTX_W-1:0]    req_context_req = '0;
   logic [SYM_W-1:0]    req_symbol = '0;
   logic [LEN_W-1:0]    req_code_length = '0;
   logic [CODE_W-1:0]   req_code_bits = '0;
   logic [SKIP_W-1:0]   req_skip_bits = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_frame_end;
   logic                rsp_code_error;
   logic                rsp_last;
   int                  fail_count;
   int                  words_waiting;
   int                  words_checked;
   int                  errors_seen;

   logic                req_took = 1'b0;
   int                  idle_cycles = 0;
   int                  rsp_stall = 0;
   int                  send_idle_odds = 0;
   int                  recv_idle_odds = 0;
   int                  words_sent = 0;
   bit                  calm = 1'b0;
   bit                  fresh_tables;
   logic [LEN_W-1:0]    plan_len  [NUM_CONTEXTS * SYMS];
   logic [CODE_W-1:0]   plan_code [NUM_CONTEXTS * SYMS];
   int                  plan_pos;
   bit                  code_stream [$];

   context_huffman_nibble_decoder i_dut (.*);
   chnd_checker i_checker (.*);

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("context_huffman_nibble_decoder verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (!calm && recv_idle_odds != 0 && $urandom_range(0, 99) < recv_idle_odds) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [CTX_W-1:0] ctx,
                            input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                            input logic [CODE_W-1:0] code, input logic [SKIP_W-1:0] skip,
                            input logic [BYTE_W-1:0] data);
      calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);
      if (!calm && send_idle_odds != 0 && $urandom_range(0, 99) < send_idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_context_req <= ctx;
      req_symbol <= sym;
      req_code_length <= len;
      req_code_bits <= code;
      req_skip_bits <= skip;
      req_data_byte <= data;
      do @(negedge clock); while (!req_took);
      if (op != OP_IGNORED) words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (words_waiting != 0);
   endtask

   // random complete prefix code by splitting leaves, sometimes with a hole
   task automatic build_context(input int ctx);
      int leaf_len  [SYMS];
      int leaf_code [SYMS];
      int order     [SYMS];
      int leaves;
      int splits;
      int pick;
      int tmp;
      int id;
      leaves = 1;
      leaf_len[0] = 0;
      leaf_code[0] = 0;
      splits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SYMS - 2) : SYMS - 1;
      for (int k = 0; k < splits; k++) begin
         do pick = $urandom_range(0, leaves - 1); while (leaf_len[pick] >= MAX_CODE_BITS);
         leaf_len[leaves] = leaf_len[pick] + 1;
         leaf_code[leaves] = leaf_code[pick] * 2 + 1;
         leaf_len[pick]++;
         leaf_code[pick] *= 2;
         leaves++;
      end
      if (leaves > 1 && $urandom_range(0, 3) == 0) leaves--;
      for (int k = 0; k < SYMS; k++) order[k] = k;
      for (int k = SYMS - 1; k > 0; k--) begin
         pick = $urandom_range(0, k);
         tmp = order[k];
         order[k] = order[pick];
         order[pick] = tmp;
      end
      for (int k = 0; k < SYMS; k++) begin
         id = ctx * SYMS + order[k];
         if (k < leaves) begin
            plan_len[id] = LEN_W'(leaf_len[k]);
            plan_code[id] = CODE_W'(leaf_code[k] | ($urandom << leaf_len[k]));
         end else begin
            tmp = $urandom_range(0, 3);
            plan_len[id] = (tmp == 0) ? LEN_W'(0) :
                           (tmp == 1) ? LEN_W'($urandom_range(9, 14)) : 4'hF;
            plan_code[id] = CODE_W'($urandom);
         end
         send_word(OP_DEFINE, CTX_W'(ctx), SYM_W'(order[k]), plan_len[id], plan_code[id],
                   SKIP_W'($urandom), BYTE_W'($urandom));
      end
   endtask

   task automatic add_symbol_code();
      int usable [$];
      int ctx;
      int s;
      int len;
      ctx = (plan_pos == 0) ? 0 : (plan_pos == 1) ? 1 : 2;
      for (int k = 0; k < SYMS; k++) begin
         if (plan_len[ctx * SYMS + k] >= 1 && plan_len[ctx * SYMS + k] <= MAX_CODE_BITS)
            usable.push_back(k);
      end
      if (usable.size() == 0) begin
         repeat (MAX_CODE_BITS) code_stream.push_back(1'($urandom));
      end else begin
         s = usable[$urandom_range(0, usable.size() - 1)];
         len = plan_len[ctx * SYMS + s];
         for (int k = len - 1; k >= 0; k--) code_stream.push_back(plan_code[ctx * SYMS + s][k]);
      end
      plan_pos = (plan_pos == 2 * FRAME_BYTES - 1) ? 0 : plan_pos + 1;
   endtask

   // start, then bytes packed from random symbols, ending in random padding
   task automatic send_stream();
      logic [BYTE_W-1:0] packed_bits;
      int skip;
      int nbytes;
      skip = $urandom_range(0, 7);
      send_word(OP_START, CTX_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
                CODE_W'($urandom), SKIP_W'(skip), BYTE_W'($urandom));
      plan_pos = 0;
      code_stream.delete();
      repeat (skip) code_stream.push_back(1'($urandom));
      nbytes = $urandom_range(4, 24);
      for (int b = 0; b < nbytes; b++) begin
         while (code_stream.size() < BYTE_W) begin
            if (b < nbytes - 2) add_symbol_code();
            else code_stream.push_back(1'($urandom));
         end
         for (int k = 0; k < BYTE_W; k++) packed_bits = {packed_bits[BYTE_W-2:0], code_stream.pop_front()};
         send_word(OP_DATA, CTX_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
                   CODE_W'($urandom), SKIP_W'($urandom), packed_bits);
      end
   endtask

   task automatic send_noise();
      int pick;
      logic [1:0] op;
      repeat ($urandom_range(4, 16)) begin
         pick = $urandom_range(0, 99);
         op = (pick < 60) ? OP_DATA : (pick < 75) ? OP_DEFINE : (pick < 85) ? OP_START :
              OP_IGNORED;
         send_word(op, CTX_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
                   CODE_W'($urandom), SKIP_W'($urandom), BYTE_W'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // one-bit codes everywhere, duplicates, lengths that never match, four words with an error on the last
      send_word(OP_IGNORED, 2'd2, 4'd5, 4'd3, 8'h5A, 3'd5, 8'hC3);
      send_word(OP_DEFINE, 2'd3, 4'd0, 4'd1, 8'h00, 3'd0, 8'h00);
      send_word(OP_DEFINE, 2'd0, 4'd15, 4'd1, 8'hFE, 3'd7, 8'hFF);
      send_word(OP_DEFINE, 2'd1, 4'd0, 4'd1, 8'h00, 3'd0, 8'h00);
      send_word(OP_DEFINE, 2'd2, 4'd10, 4'd1, 8'h00, 3'd0, 8'h00);
      send_word(OP_DEFINE, 2'd2, 4'd3, 4'd1, 8'h00, 3'd0, 8'h00);
      send_word(OP_DEFINE, 2'd2, 4'd7, 4'd0, 8'h80, 3'd0, 8'h00);
      send_word(OP_DEFINE, 2'd2, 4'd11, 4'd9, 8'hFF, 3'd0, 8'h00);
      send_word(OP_DEFINE, 2'd2, 4'd12, 4'd14, 8'h7F, 3'd0, 8'h00);
      send_word(OP_DEFINE, 2'd2, 4'd1, 4'd8, 8'hFF, 3'd0, 8'h00);
      send_word(OP_START, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'h00);
      send_word(OP_DATA, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'h00);
      send_word(OP_DATA, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'h00);
      send_word(OP_DATA, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'h80);
      send_word(OP_DATA, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'hFF);
      send_word(OP_DATA, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'h00);
      send_word(OP_START, 2'd3, 4'd15, 4'd15, 8'hFF, 3'd7, 8'hFF);
      send_word(OP_DATA, 2'd3, 4'd15, 4'd15, 8'hFF, 3'd0, 8'hFF);
      send_word(OP_DATA, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'h7F);
      send_word(OP_DEFINE, 2'd2, 4'd10, 4'd15, 8'hFF, 3'd0, 8'h00);
      send_word(OP_START, 2'd0, 4'd0, 4'd0, 8'h00, 3'd3, 8'h00);
      send_word(OP_DATA, 2'd0, 4'd0, 4'd0, 8'h00, 3'd0, 8'hA5);
      wait_drained();

      fresh_tables = 1'b1;
      while (words_sent < TOTAL_WORDS) begin
         send_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         recv_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         if (!fresh_tables && $urandom_range(0, 3) == 0) begin
            send_noise();
         end else begin
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
               if (fresh_tables || $urandom_range(0, 2) == 0) build_context(c);
            end
            fresh_tables = 1'b0;
            send_stream();
         end
         if ($urandom_range(0, 4) == 0) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("covered %0d req words and %0d rsp words, %0d carrying code_error",
               words_sent, words_checked, errors_seen);
      if (fail_count == 0 && words_waiting == 0) begin
         $display("context_huffman_nibble_decoder verification clean");
      end else begin
         $display("context_huffman_nibble_decoder verification failed");
      end
      $finish;
   end

endmodule
